// ----- rtl/core/vga_bank_address_translate_macros.svh -----
// assertion helpers shared by the translator rtl
`ifndef VGA_BANK_ADDRESS_TRANSLATE_MACROS_SVH
`define VGA_BANK_ADDRESS_TRANSLATE_MACROS_SVH

// clocked check, off while reset is asserted
`define VBAT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define VBAT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/vbat_pkg.sv -----
package vbat_pkg;

	localparam int unsigned BANK_W   = 8;
	localparam int unsigned WIN_W    = 2;
	localparam int unsigned MSZ_W    = 2;
	localparam int unsigned FLAGS_W  = 3;
	localparam int unsigned OFFSET_W = 17;
	localparam int unsigned ADDR_W   = 21;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [ADDR_W-1:0] SLOT_STEP = 21'h08000;
	localparam logic [ADDR_W-1:0] MASK_512K = 21'h07ffff;
	localparam logic [ADDR_W-1:0] MASK_1M   = 21'h0fffff;
	localparam logic [ADDR_W-1:0] LOW_KEEP  = 21'h00fffc;

	localparam logic [WIN_W-1:0] WIN_64K = 2'd1;
	localparam logic [MSZ_W-1:0] MSZ_1M  = 2'd3;
	localparam logic [MSZ_W-1:0] MSZ_RESET = 2'd1;

	localparam int unsigned FLAG_HIGHRES = 0;
	localparam int unsigned FLAG_DWORD   = 1;
	localparam int unsigned FLAG_CHAIN4  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIMARY_BANK   = 3'd0,
		REG_SECONDARY_BANK = 3'd1,
		REG_WINDOW_SELECT  = 3'd2,
		REG_DUAL_BANK      = 3'd3,
		REG_MEMORY_SIZE    = 3'd4,
		REG_SPLIT_RW       = 3'd5,
		REG_DISPLAY_FLAGS  = 3'd6
	} reg_index_t;

	// register contents plus values derived from them
	typedef struct packed {
		logic [BANK_W-1:0] primary_bank;
		logic [BANK_W-1:0] secondary_bank;
		logic [WIN_W-1:0]  window_select;
		logic              dual_bank_enable;
		logic              split_read_write;
		logic [ADDR_W-1:0] step;
		logic [ADDR_W-1:0] slot1_mask;
		logic              swizzle_en;
	} cfg_t;

endpackage

// ----- rtl/core/vbat_cfg.sv -----
module vbat_cfg
	import vbat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [BANK_W-1:0]  primary_bank_q;
	logic [BANK_W-1:0]  secondary_bank_q;
	logic [WIN_W-1:0]   window_select_q;
	logic               dual_bank_q;
	logic [MSZ_W-1:0]   memory_size_q;
	logic               split_rw_q;
	logic [FLAGS_W-1:0] display_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_bank_q   <= '0;
			secondary_bank_q <= '0;
			window_select_q  <= '0;
			dual_bank_q      <= 1'b0;
			memory_size_q    <= MSZ_RESET;
			split_rw_q       <= 1'b0;
			display_flags_q  <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PRIMARY_BANK:   primary_bank_q   <= cfg_data[BANK_W-1:0];
				REG_SECONDARY_BANK: secondary_bank_q <= cfg_data[BANK_W-1:0];
				REG_WINDOW_SELECT:  window_select_q  <= cfg_data[WIN_W-1:0];
				REG_DUAL_BANK:      dual_bank_q      <= cfg_data[0];
				REG_MEMORY_SIZE:    memory_size_q    <= cfg_data[MSZ_W-1:0];
				REG_SPLIT_RW:       split_rw_q       <= cfg_data[0];
				REG_DISPLAY_FLAGS:  display_flags_q  <= cfg_data[FLAGS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.primary_bank     = primary_bank_q;
		cfg.secondary_bank   = secondary_bank_q;
		cfg.window_select    = window_select_q;
		cfg.dual_bank_enable = dual_bank_q;
		cfg.split_read_write = split_rw_q;
		// small windows give odd slots no 32k step
		cfg.step       = window_select_q[1] ? '0 : SLOT_STEP;
		cfg.slot1_mask = (memory_size_q == MSZ_1M) ? MASK_1M : MASK_512K;
		cfg.swizzle_en = display_flags_q[FLAG_HIGHRES] && display_flags_q[FLAG_DWORD]
			&& !display_flags_q[FLAG_CHAIN4] && (window_select_q == WIN_64K)
			&& (memory_size_q == MSZ_1M);
	end

endmodule

// ----- rtl/core/vbat_xlate.sv -----
module vbat_xlate
	import vbat_pkg::*;
(
	input  cfg_t                cfg,
	input  logic                kind,
	input  logic [OFFSET_W-1:0] host_offset,
	output logic [ADDR_W-1:0]   vram_address
);

	logic [1:0]        slot;
	logic              odd;
	logic [ADDR_W-1:0] p_base;
	logic [ADDR_W-1:0] s_base;
	logic [ADDR_W-1:0] rw_base;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] linear;
	logic [1:0]        plane;
	logic [ADDR_W-1:0] swizzled;

	assign slot   = host_offset[16:15];
	assign odd    = slot[0];
	assign p_base = {1'b0, cfg.primary_bank, 12'h000};
	assign s_base = {1'b0, cfg.secondary_bank, 12'h000};
	assign rw_base = kind ? s_base : p_base;

	always_comb begin
		if (cfg.split_read_write) begin
			base = odd ? rw_base + cfg.step : rw_base;
		end else if (cfg.dual_bank_enable) begin
			if (cfg.window_select != '0) begin
				base = odd ? p_base + cfg.step : s_base;
			end else begin
				case (slot)
					2'd0:    base = s_base;
					2'd1:    base = s_base + cfg.step;
					2'd2:    base = p_base;
					default: base = p_base + cfg.step;
				endcase
			end
		end else begin
			base = odd ? p_base + cfg.step : p_base;
		end
		// only slot 1 is clipped to installed memory
		if (slot == 2'd1)
			base = base & cfg.slot1_mask;
	end

	assign linear = {6'b0, host_offset[14:0]} + base;
	assign plane  = linear[1:0];

	// plane number moves into bits 17:16
	assign swizzled = {16'b0, linear[20:16]} | {3'b0, plane, 16'h0000}
		| (linear & LOW_KEEP);

	assign vram_address = (cfg.swizzle_en && (linear[17:16] != plane)) ? swizzled : linear;

endmodule

// ----- rtl/core/vga_bank_address_translate.sv -----
// host window address translator
// input channel: in_valid / in_stall carry one access beat (kind, host_offset);
// kind 0 is a read, 1 is a write. output channel: out_valid / out_stall carry
// the translated vram_address, one result beat per access, in order.
// config port: cfg_we writes cfg_data into register cfg_index;
// indexes beyond the register list are dropped. write only while idle.
// path: the input register loads at the accepting edge, then the result
// register loads from it once it may advance, and out_valid rises with it.
// throughput: one access per cycle while not stalled; the bank base select,
// the 21-bit add and the plane swizzle all fit between the two registers.
// stall: with out_stall high the result register holds and the input register
// still takes one more beat; in_stall rises only when both are full.
// reset: arst_n clears both valid flags and returns the bank registers to
// zero with memory size code 1; no clearing pass is needed.
`include "vga_bank_address_translate_macros.svh"

module vga_bank_address_translate
	import vbat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [OFFSET_W-1:0]   host_offset,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ADDR_W-1:0]     vram_address
);

	cfg_t                cfg;
	logic                valid_s1;
	logic                kind_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   addr_next;
	logic                advance;
	logic                in_take;

	vbat_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vbat_xlate u_xlate (
		.cfg          (cfg),
		.kind         (kind_s1),
		.host_offset  (offset_s1),
		.vram_address (addr_next)
	);

	// result register can load when empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (advance || !valid_s1)
				valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1   <= kind;
			offset_s1 <= host_offset;
		end
		if (advance && valid_s1)
			addr_q <= addr_next;
	end

	assign out_valid    = out_valid_q;
	assign vram_address = addr_q;

	`VBAT_ASSERT_ALWAYS(a_stall_only_when_full,
		in_stall |-> (valid_s1 && out_valid_q && out_stall),
		"input stalled while a stage is free")
	`VBAT_ASSERT(a_s1_moves_on,
		(valid_s1 && (!out_valid_q || !out_stall)) |=> out_valid_q,
		"staged beat did not reach the result register")
	`VBAT_ASSERT(a_s1_holds,
		(valid_s1 && in_stall) |=> (valid_s1 && $stable(kind_s1) && $stable(offset_s1)),
		"staged beat changed while blocked")

endmodule
